// ===== rtl/rlrg_pkg.sv =====
// Shared types, constants and the control store of the random level ramp generator.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps

package rlrg_pkg;

	localparam int LINES     = 4;
	localparam int LINE_W    = 2;
	localparam int LVL_W     = 7;
	localparam int RAND_W    = 16;
	localparam int ACC_W     = 8;
	localparam int NOTE_W    = 8;
	localparam int CHAN_W    = 4;
	localparam int UPC_W     = 4;
	localparam int ITER_W    = 5;
	localparam int MOD_ITERS = RAND_W;
	localparam int DIV_ITERS = LVL_W;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;

	localparam logic [LVL_W-1:0]  RST_NOTE_BASE  = 7'd60;
	localparam logic [CHAN_W-1:0] RST_CHANNEL    = 4'd0;
	localparam logic [LVL_W-1:0]  RST_MIN_BRIGHT = 7'd0;
	localparam logic [LVL_W-1:0]  RST_MAX_BRIGHT = 7'd127;
	localparam logic [LVL_W-1:0]  RST_MIN_TIME   = 7'd1;
	localparam logic [LVL_W-1:0]  RST_MAX_TIME   = 7'd32;

	typedef enum logic [2:0] {
		REG_NOTE_BASE  = 3'd0,
		REG_CHANNEL    = 3'd1,
		REG_MIN_BRIGHT = 3'd2,
		REG_MAX_BRIGHT = 3'd3,
		REG_MIN_TIME   = 3'd4,
		REG_MAX_TIME   = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		UOP_NOP,
		UOP_LATCH,
		UOP_MOD_LOAD,
		UOP_DIV_ITER,
		UOP_PICK,
		UOP_COMMIT,
		UOP_STEP,
		UOP_NULL
	} uop_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_WAIT_IN,
		COND_BAD_LINE,
		COND_STEPS_LEFT,
		COND_ITER_MORE,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		uop_t             uop;
		cond_t            cond;
		logic [UPC_W-1:0] target;
		logic             last;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic bad_line;
		logic steps_nz;
		logic iter_more;
		logic out_busy;
	} seq_status_t;

	typedef struct packed {
		uop_t uop;
		logic go;
		logic in_ready;
	} seq_ctrl_t;

	typedef struct packed {
		logic [LVL_W-1:0]  note_base;
		logic [CHAN_W-1:0] midi_channel;
		logic [LVL_W-1:0]  min_bright;
		logic [LVL_W-1:0]  max_bright;
		logic [LVL_W-1:0]  min_time;
		logic [LVL_W-1:0]  max_time;
	} cfg_t;

	typedef struct packed {
		logic [LINE_W-1:0] line_out;
		logic [NOTE_W-1:0] note;
		logic [CHAN_W-1:0] channel;
		logic [LVL_W-1:0]  level;
		logic              changed;
		logic              restarted;
	} result_t;

	// Program addresses.
	localparam logic [UPC_W-1:0] PC_IDLE     = 4'd0;
	localparam logic [UPC_W-1:0] PC_CHECK    = 4'd1;
	localparam logic [UPC_W-1:0] PC_DISPATCH = 4'd2;
	localparam logic [UPC_W-1:0] PC_MOD_LOAD = 4'd3;
	localparam logic [UPC_W-1:0] PC_MOD_LOOP = 4'd4;
	localparam logic [UPC_W-1:0] PC_PICK     = 4'd5;
	localparam logic [UPC_W-1:0] PC_DIV_LOOP = 4'd6;
	localparam logic [UPC_W-1:0] PC_COMMIT   = 4'd7;
	localparam logic [UPC_W-1:0] PC_STEP     = 4'd8;
	localparam logic [UPC_W-1:0] PC_NULL     = 4'd9;

	// The control store: a jump is taken when its condition holds, otherwise the
	// program falls through, or returns to idle on a word marked last.
	function automatic uword_t ucode_rom(input logic [UPC_W-1:0] pc);
		uword_t w;
		case (pc)
			PC_IDLE:     w = '{UOP_LATCH,    COND_WAIT_IN,    PC_IDLE,     1'b0};
			PC_CHECK:    w = '{UOP_NOP,      COND_BAD_LINE,   PC_NULL,     1'b0};
			PC_DISPATCH: w = '{UOP_NOP,      COND_STEPS_LEFT, PC_STEP,     1'b0};
			PC_MOD_LOAD: w = '{UOP_MOD_LOAD, COND_NEVER,      PC_IDLE,     1'b0};
			PC_MOD_LOOP: w = '{UOP_DIV_ITER, COND_ITER_MORE,  PC_MOD_LOOP, 1'b0};
			PC_PICK:     w = '{UOP_PICK,     COND_NEVER,      PC_IDLE,     1'b0};
			PC_DIV_LOOP: w = '{UOP_DIV_ITER, COND_ITER_MORE,  PC_DIV_LOOP, 1'b0};
			PC_COMMIT:   w = '{UOP_COMMIT,   COND_OUT_BUSY,   PC_COMMIT,   1'b1};
			PC_STEP:     w = '{UOP_STEP,     COND_OUT_BUSY,   PC_STEP,     1'b1};
			PC_NULL:     w = '{UOP_NULL,     COND_OUT_BUSY,   PC_NULL,     1'b1};
			default:     w = '{UOP_NOP,      COND_NEVER,      PC_IDLE,     1'b1};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/rlrg_divider.sv =====
// Bit-serial restoring divider: a 16-bit dividend by a 7-bit divisor, one bit per step.
// Depends on rlrg_pkg for widths.
`timescale 1ns / 1ps

module rlrg_divider (
	input  logic                            clk,
	input  logic                            load,
	input  logic                            iter,
	input  logic [rlrg_pkg::RAND_W-1:0]     dividend,
	input  logic [rlrg_pkg::LVL_W-1:0]      divisor,
	output logic [rlrg_pkg::RAND_W-1:0]     quot,
	output logic [rlrg_pkg::LVL_W-1:0]      rem
);

	logic [rlrg_pkg::RAND_W-1:0] shift_q;
	logic [rlrg_pkg::LVL_W-1:0]  rem_q;
	logic [rlrg_pkg::LVL_W-1:0]  divisor_q;
	logic [rlrg_pkg::LVL_W:0]    trial;
	logic                        fits;
	logic [rlrg_pkg::LVL_W:0]    diff;

	always_comb begin
		trial = {rem_q, shift_q[rlrg_pkg::RAND_W-1]};
		fits  = (trial >= {1'b0, divisor_q});
		diff  = trial - {1'b0, divisor_q};
	end

	// The partial remainder stays below the divisor, so seven bits hold it.
	always_ff @(posedge clk) begin
		if (load) begin
			shift_q   <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (iter) begin
			shift_q <= {shift_q[rlrg_pkg::RAND_W-2:0], fits};
			rem_q   <= fits ? diff[rlrg_pkg::LVL_W-1:0] : trial[rlrg_pkg::LVL_W-1:0];
		end
	end

	assign quot = shift_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/rlrg_sequencer.sv =====
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
// Depends on rlrg_pkg for the control word, status and control types.
`timescale 1ns / 1ps

module rlrg_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rlrg_pkg::seq_status_t status,
	output rlrg_pkg::seq_ctrl_t   ctrl
);

	logic [rlrg_pkg::UPC_W-1:0] upc_q;
	logic [rlrg_pkg::UPC_W-1:0] upc_next;
	rlrg_pkg::uword_t           word;
	logic                       jump;
	logic                       go;

	assign word = rlrg_pkg::ucode_rom(upc_q);

	always_comb begin
		case (word.cond)
			rlrg_pkg::COND_NEVER:      jump = 1'b0;
			rlrg_pkg::COND_WAIT_IN:    jump = !status.in_valid;
			rlrg_pkg::COND_BAD_LINE:   jump = status.bad_line;
			rlrg_pkg::COND_STEPS_LEFT: jump = status.steps_nz;
			rlrg_pkg::COND_ITER_MORE:  jump = status.iter_more;
			rlrg_pkg::COND_OUT_BUSY:   jump = status.out_busy;
			default:                   jump = 1'b0;
		endcase
	end

	// Next step.
	always_comb begin
		if (jump) begin
			upc_next = word.target;
		end else if (word.last) begin
			upc_next = rlrg_pkg::PC_IDLE;
		end else begin
			upc_next = upc_q + 1'b1;
		end
	end

	// Control outputs: a wait step acts only in the cycle it stops waiting.
	always_comb begin
		case (word.cond)
			rlrg_pkg::COND_WAIT_IN:  go = status.in_valid;
			rlrg_pkg::COND_OUT_BUSY: go = !status.out_busy;
			default:                 go = 1'b1;
		endcase
		ctrl.uop      = word.uop;
		ctrl.go       = go;
		ctrl.in_ready = (upc_q == rlrg_pkg::PC_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= rlrg_pkg::PC_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

// ===== rtl/rlrg_datapath.sv =====
// Datapath of the ramp generator: per-line ramp state, two serial dividers and step logic.
// Depends on rlrg_pkg and rlrg_divider; driven by rlrg_sequencer.
`timescale 1ns / 1ps

module rlrg_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rlrg_pkg::seq_ctrl_t             ctrl,
	input  rlrg_pkg::cfg_t                  cfg,
	input  logic [rlrg_pkg::LINE_W-1:0]     in_line,
	input  logic [rlrg_pkg::RAND_W-1:0]     in_rand_dest,
	input  logic [rlrg_pkg::RAND_W-1:0]     in_rand_time,
	output logic                            bad_line,
	output logic                            steps_nz,
	output logic                            iter_more,
	output logic                            res_valid,
	output rlrg_pkg::result_t               res
);

	localparam int LVL_W = rlrg_pkg::LVL_W;
	localparam int ACC_W = rlrg_pkg::ACC_W;

	// Per-line state.
	logic [LVL_W-1:0] level_q  [rlrg_pkg::LINES];
	logic [LVL_W-1:0] target_q [rlrg_pkg::LINES];
	logic             rising_q [rlrg_pkg::LINES];
	logic [LVL_W-1:0] steps_q  [rlrg_pkg::LINES];
	logic [LVL_W-1:0] length_q [rlrg_pkg::LINES];
	logic [LVL_W-1:0] quot_q   [rlrg_pkg::LINES];
	logic [LVL_W-1:0] remd_q   [rlrg_pkg::LINES];
	logic [ACC_W-1:0] accum_q  [rlrg_pkg::LINES];

	// Item being worked on.
	logic [rlrg_pkg::LINE_W-1:0] line_q;
	logic [rlrg_pkg::RAND_W-1:0] rand_dest_q;
	logic [rlrg_pkg::RAND_W-1:0] rand_time_q;
	logic [LVL_W-1:0]            goal_q;
	logic [LVL_W-1:0]            len_q;
	logic                        rising_new_q;
	logic [rlrg_pkg::ITER_W-1:0] iter_q;

	logic [rlrg_pkg::RAND_W-1:0] dest_quot, time_quot;
	logic [LVL_W-1:0]            dest_rem, time_rem;
	logic [rlrg_pkg::RAND_W-1:0] dest_dividend;
	logic [LVL_W-1:0]            dest_divisor;
	logic                        div_load, div_iter;

	logic [LVL_W-1:0] span_b, span_t;
	logic [LVL_W-1:0] goal, len_new, goal_gap, old_target;
	logic [LVL_W-1:0] cur_level, stepped, next_level;
	logic [ACC_W:0]   acc_sum;
	logic             carry;
	logic [ACC_W-1:0] acc_next;
	logic [rlrg_pkg::NOTE_W-1:0] note;

	logic do_commit, do_step;

	always_comb begin
		span_b = (cfg.max_bright > cfg.min_bright) ? cfg.max_bright - cfg.min_bright : '0;
		span_t = (cfg.max_time > cfg.min_time) ? cfg.max_time - cfg.min_time : '0;
		goal    = (span_b == '0) ? cfg.min_bright : cfg.min_bright + dest_rem;
		len_new = (span_t == '0) ? cfg.min_time : cfg.min_time + time_rem;
		old_target = target_q[line_q];
		goal_gap = (goal > old_target) ? goal - old_target : old_target - goal;
	end

	// The target lane first reduces the random word, then divides the distance by the
	// new length; the distance is placed in the top bits so seven steps suffice.
	always_comb begin
		div_load = ctrl.go && (ctrl.uop == rlrg_pkg::UOP_MOD_LOAD ||
			ctrl.uop == rlrg_pkg::UOP_PICK);
		div_iter = ctrl.go && (ctrl.uop == rlrg_pkg::UOP_DIV_ITER);
		if (ctrl.uop == rlrg_pkg::UOP_MOD_LOAD) begin
			dest_dividend = rand_dest_q;
			dest_divisor  = span_b;
		end else begin
			dest_dividend = {goal_gap, {(rlrg_pkg::RAND_W - LVL_W){1'b0}}};
			dest_divisor  = len_new;
		end
	end

	rlrg_divider u_dest_div (
		.clk      (clk),
		.load     (div_load),
		.iter     (div_iter),
		.dividend (dest_dividend),
		.divisor  (dest_divisor),
		.quot     (dest_quot),
		.rem      (dest_rem)
	);

	rlrg_divider u_time_div (
		.clk      (clk),
		.load     (div_load && ctrl.uop == rlrg_pkg::UOP_MOD_LOAD),
		.iter     (div_iter),
		.dividend (rand_time_q),
		.divisor  (span_t),
		.quot     (time_quot),
		.rem      (time_rem)
	);

	// One Bresenham step.
	always_comb begin
		cur_level = level_q[line_q];
		stepped   = rising_q[line_q] ? cur_level + quot_q[line_q] : cur_level - quot_q[line_q];
		acc_sum   = {1'b0, accum_q[line_q]} + {{(ACC_W + 1 - LVL_W){1'b0}}, remd_q[line_q]};
		carry     = (acc_sum >= {{(ACC_W + 1 - LVL_W){1'b0}}, length_q[line_q]});
		if (carry) begin
			next_level = rising_q[line_q] ? stepped + 1'b1 : stepped - 1'b1;
			acc_next   = ACC_W'(acc_sum - {{(ACC_W + 1 - LVL_W){1'b0}}, length_q[line_q]});
		end else begin
			next_level = stepped;
			acc_next   = acc_sum[ACC_W-1:0];
		end
	end

	assign do_commit = ctrl.go && (ctrl.uop == rlrg_pkg::UOP_COMMIT);
	assign do_step   = ctrl.go && (ctrl.uop == rlrg_pkg::UOP_STEP);

	assign bad_line  = (int'(line_q) >= rlrg_pkg::LINES);
	assign steps_nz  = (steps_q[line_q] != '0);
	assign iter_more = (iter_q != rlrg_pkg::ITER_W'(1));

	always_ff @(posedge clk) begin
		if (ctrl.go && ctrl.uop == rlrg_pkg::UOP_LATCH) begin
			line_q      <= in_line;
			rand_dest_q <= in_rand_dest;
			rand_time_q <= in_rand_time;
		end
		if (ctrl.go && ctrl.uop == rlrg_pkg::UOP_MOD_LOAD) begin
			iter_q <= rlrg_pkg::ITER_W'(rlrg_pkg::MOD_ITERS);
		end else if (ctrl.go && ctrl.uop == rlrg_pkg::UOP_PICK) begin
			iter_q       <= rlrg_pkg::ITER_W'(rlrg_pkg::DIV_ITERS);
			goal_q       <= goal;
			len_q        <= len_new;
			rising_new_q <= (goal > old_target);
		end else if (div_iter) begin
			iter_q <= iter_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rlrg_pkg::LINES; i++) begin
				level_q[i]  <= '0;
				target_q[i] <= '0;
				rising_q[i] <= 1'b0;
				steps_q[i]  <= '0;
				length_q[i] <= '0;
				quot_q[i]   <= '0;
				remd_q[i]   <= '0;
				accum_q[i]  <= '0;
			end
		end else if (do_commit) begin
			level_q[line_q]  <= old_target;
			target_q[line_q] <= goal_q;
			rising_q[line_q] <= rising_new_q;
			steps_q[line_q]  <= len_q;
			length_q[line_q] <= len_q;
			quot_q[line_q]   <= (len_q != '0) ? dest_quot[LVL_W-1:0] : '0;
			remd_q[line_q]   <= (len_q != '0) ? dest_rem : '0;
			accum_q[line_q]  <= '0;
		end else if (do_step) begin
			level_q[line_q] <= next_level;
			steps_q[line_q] <= steps_q[line_q] - 1'b1;
			accum_q[line_q] <= acc_next;
		end
	end

	always_comb begin
		note = {1'b0, cfg.note_base} + {{(rlrg_pkg::NOTE_W - rlrg_pkg::LINE_W){1'b0}}, line_q};
		res.line_out  = line_q;
		res.note      = note;
		res.channel   = cfg.midi_channel;
		res.level     = '0;
		res.changed   = 1'b0;
		res.restarted = 1'b0;
		case (ctrl.uop)
			rlrg_pkg::UOP_COMMIT: begin
				res.level     = old_target;
				res.restarted = 1'b1;
			end
			rlrg_pkg::UOP_STEP: begin
				res.level   = next_level;
				res.changed = (next_level != cur_level);
			end
			default: begin
				res.level = '0;
			end
		endcase
		res_valid = ctrl.go && (ctrl.uop == rlrg_pkg::UOP_COMMIT ||
			ctrl.uop == rlrg_pkg::UOP_STEP || ctrl.uop == rlrg_pkg::UOP_NULL);
	end

endmodule

// ===== rtl/random_level_ramp_generator.sv =====
// Top level of the random level ramp generator: register port, sequencer, datapath
// and output register. Depends on rlrg_pkg, rlrg_sequencer and rlrg_datapath.
`timescale 1ns / 1ps

// Each input item is a tick for one dimmer line and carries two random words. A line
// with steps left moves its level one Bresenham step toward its target; a line with
// no steps left starts a new ramp (random target and length from the bounds in the
// registers) and reports its old target as the level. Every item gives exactly one
// result item. A microprogram sequences the work one item at a time: a step tick
// passes through the check, dispatch and step words before its result reaches the
// result register; a restart tick instead runs two 16-step serial remainder passes
// side by side on the random words, then a 7-step serial division of the distance
// by the new length before its commit word; a result word waits while the output is full.
// After reset all lines are at level zero with no steps left, so the first tick of
// each line restarts it; no clearing pass is needed. The result register lets the
// next item be accepted while a result still waits to be taken. Registers are
// written over the APB port at byte addresses 4*i and should be changed only while
// the block is idle.
module random_level_ramp_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input items: line [1:0], rand_dest [17:2], rand_time [33:18], zero fill above.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rlrg_pkg::IN_DATA_W-1:0]      s_tdata,
	// Result items: line_out [1:0], note [9:2], channel [13:10], level [20:14], zero fill.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rlrg_pkg::OUT_DATA_W-1:0]     m_tdata,
	// Result flags: changed [0], restarted [1].
	output logic [rlrg_pkg::OUT_USER_W-1:0]     m_tuser,
	// Register port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rlrg_pkg::ADDR_W-1:0]         paddr,
	input  logic [rlrg_pkg::DATA_W-1:0]         pwdata,
	output logic [rlrg_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);

	rlrg_pkg::cfg_t        cfg_q;
	rlrg_pkg::seq_status_t status;
	rlrg_pkg::seq_ctrl_t   ctrl;
	rlrg_pkg::result_t     res;
	rlrg_pkg::result_t     out_q;
	rlrg_pkg::reg_idx_t    reg_idx;
	logic                  out_valid_q;
	logic                  res_valid;
	logic                  bad_line, steps_nz, iter_more;
	logic                  cfg_write;

	// Register port: always ready, registers decoded on the word address.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = rlrg_pkg::reg_idx_t'(paddr[rlrg_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.note_base    <= rlrg_pkg::RST_NOTE_BASE;
			cfg_q.midi_channel <= rlrg_pkg::RST_CHANNEL;
			cfg_q.min_bright   <= rlrg_pkg::RST_MIN_BRIGHT;
			cfg_q.max_bright   <= rlrg_pkg::RST_MAX_BRIGHT;
			cfg_q.min_time     <= rlrg_pkg::RST_MIN_TIME;
			cfg_q.max_time     <= rlrg_pkg::RST_MAX_TIME;
		end else if (cfg_write) begin
			case (reg_idx)
				rlrg_pkg::REG_NOTE_BASE:  cfg_q.note_base    <= pwdata[rlrg_pkg::LVL_W-1:0];
				rlrg_pkg::REG_CHANNEL:    cfg_q.midi_channel <= pwdata[rlrg_pkg::CHAN_W-1:0];
				rlrg_pkg::REG_MIN_BRIGHT: cfg_q.min_bright   <= pwdata[rlrg_pkg::LVL_W-1:0];
				rlrg_pkg::REG_MAX_BRIGHT: cfg_q.max_bright   <= pwdata[rlrg_pkg::LVL_W-1:0];
				rlrg_pkg::REG_MIN_TIME:   cfg_q.min_time     <= pwdata[rlrg_pkg::LVL_W-1:0];
				rlrg_pkg::REG_MAX_TIME:   cfg_q.max_time     <= pwdata[rlrg_pkg::LVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rlrg_pkg::REG_NOTE_BASE:  prdata = rlrg_pkg::DATA_W'(cfg_q.note_base);
			rlrg_pkg::REG_CHANNEL:    prdata = rlrg_pkg::DATA_W'(cfg_q.midi_channel);
			rlrg_pkg::REG_MIN_BRIGHT: prdata = rlrg_pkg::DATA_W'(cfg_q.min_bright);
			rlrg_pkg::REG_MAX_BRIGHT: prdata = rlrg_pkg::DATA_W'(cfg_q.max_bright);
			rlrg_pkg::REG_MIN_TIME:   prdata = rlrg_pkg::DATA_W'(cfg_q.min_time);
			rlrg_pkg::REG_MAX_TIME:   prdata = rlrg_pkg::DATA_W'(cfg_q.max_time);
			default:                  prdata = '0;
		endcase
	end

	// The sequencer waits on a result step while the output register still holds an
	// item that the downstream side has not taken in this cycle.
	always_comb begin
		status.in_valid  = s_tvalid;
		status.bad_line  = bad_line;
		status.steps_nz  = steps_nz;
		status.iter_more = iter_more;
		status.out_busy  = out_valid_q && !m_tready;
	end

	rlrg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign s_tready = ctrl.in_ready;

	rlrg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.cfg          (cfg_q),
		.in_line      (s_tdata[1:0]),
		.in_rand_dest (s_tdata[17:2]),
		.in_rand_time (s_tdata[33:18]),
		.bad_line     (bad_line),
		.steps_nz     (steps_nz),
		.iter_more    (iter_more),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.level, out_q.channel, out_q.note, out_q.line_out};
	assign m_tuser  = {out_q.restarted, out_q.changed};

endmodule
